/* design/esp_pkg.sv */
// Shared types and constants of the even strip point upscaler.
// No dependencies; every other file of the block imports this package.
package esp_pkg;

   localparam int unsigned MaxSourceDim  = 4096;
   localparam int unsigned MaxTargetDim  = 8192;
   localparam int unsigned AddrWidth     = $clog2(MaxSourceDim);
   localparam int unsigned DimWidth      = 13;
   localparam int unsigned TgtWidth      = 14;
   localparam int unsigned CountWidth    = 14;
   localparam int unsigned PixelWidth    = 32;
   localparam int unsigned StatusWidth   = 3;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 14;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_ODD_TARGET  = 3'd1,
      STATUS_ODD_SOURCE  = 3'd2,
      STATUS_NOT_SMALLER = 3'd3,
      STATUS_NO_MULTIPLE = 3'd4
   } status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SOURCE_WIDTH  = 3'd0,
      CSR_SOURCE_HEIGHT = 3'd1,
      CSR_TARGET_WIDTH  = 3'd2,
      CSR_TARGET_HEIGHT = 3'd3,
      CSR_HALF_RES      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_RATIO,
      TOP_FILL_COL,
      TOP_FILL_ROW
   } top_state_type;

   typedef enum logic [1:0] {
      RAT_IDLE,
      RAT_DIV_X,
      RAT_DIV_Y
   } ratio_state_type;

   typedef enum logic [1:0] {
      FILL_IDLE,
      FILL_PREP,
      FILL_RUN,
      FILL_FLUSH
   } fill_state_type;

   // Write port of a count memory
   typedef struct packed {
      logic                  en;
      logic [AddrWidth-1:0]  addr;
      logic [CountWidth-1:0] data;
   } esp_wr_type;

endpackage

/* design/esp_count_mem.sv */
// Strip count memory: one write port, one read port with registered data.
// Depends on esp_pkg.
module esp_count_mem import esp_pkg::*; (
   input  logic                  clock,
   input  esp_wr_type            wr,
   input  logic                  rd_en,
   input  logic [AddrWidth-1:0]  rd_addr,
   output logic [CountWidth-1:0] rd_data
);

   logic [CountWidth-1:0] mem_ff [MaxSourceDim];
   logic [CountWidth-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/esp_ratio.sv */
// Size checks and scale ratio choice, with a shared restoring divider
// (one quotient bit per cycle). Depends on esp_pkg.
module esp_ratio import esp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                abort,
   input  logic [DimWidth-1:0] source_width,
   input  logic [DimWidth-1:0] source_height,
   input  logic [TgtWidth-1:0] target_width,
   input  logic [TgtWidth-1:0] target_height,
   input  logic                half_resolution,
   output logic                done,
   output status_type          status,
   output logic [DimWidth-1:0] ratio,
   output logic [DimWidth-1:0] strips_w,
   output logic [DimWidth-1:0] strips_h
);

   localparam int unsigned CntWidth = $clog2(TgtWidth);

   ratio_state_type       state_ff, state_in;
   logic                  done_ff;
   status_type            status_ff;
   logic [DimWidth-1:0]   ratio_ff;
   logic [DimWidth-1:0]   sw_ff, sh_ff;
   logic [TgtWidth-1:0]   quo_ff, quo_in;
   logic [TgtWidth-1:0]   rem_ff, rem_in;
   logic [CntWidth-1:0]   cnt_ff;
   logic [TgtWidth-1:0]   xq_ff;
   logic                  xz_ff;
   logic [DimWidth-1:0]   sw_eff, sh_eff;
   status_type            pre_status;
   logic [DimWidth-1:0]   divisor;
   logic [TgtWidth-1:0]   shifted;
   logic                  ge;
   logic                  last_step;
   logic                  xeven, yeven;
   status_type            final_status;
   logic [DimWidth-1:0]   final_ratio;

   // checks done before any division
   always_comb begin
      sw_eff = half_resolution ? {1'b0, source_width[DimWidth-1:1]} : source_width;
      sh_eff = half_resolution ? {1'b0, source_height[DimWidth-1:1]} : source_height;
      priority if (target_width[0] || target_height[0]) begin
         pre_status = STATUS_ODD_TARGET;
      end else if (half_resolution && (source_width[0] || source_height[0])) begin
         pre_status = STATUS_ODD_SOURCE;
      end else if (source_width > DimWidth'(MaxSourceDim)
                   || source_height > DimWidth'(MaxSourceDim)
                   || target_width == '0 || target_height == '0
                   || target_width > TgtWidth'(MaxTargetDim)
                   || target_height > TgtWidth'(MaxTargetDim)) begin
         pre_status = STATUS_NO_MULTIPLE;
      end else if (sw_eff == '0 || sh_eff == '0) begin
         pre_status = STATUS_NO_MULTIPLE;
      end else begin
         pre_status = STATUS_OK;
      end
   end

   // divider step
   always_comb begin
      divisor   = (state_ff == RAT_DIV_X) ? sw_ff : sh_ff;
      shifted   = {rem_ff[TgtWidth-2:0], quo_ff[TgtWidth-1]};
      ge        = shifted >= {1'b0, divisor};
      rem_in    = ge ? (shifted - {1'b0, divisor}) : shifted;
      quo_in    = {quo_ff[TgtWidth-2:0], ge};
      last_step = cnt_ff == CntWidth'(TgtWidth - 1);
   end

   // ratio choice once both quotients are known (y quotient is quo_in)
   always_comb begin
      xeven       = xz_ff && !xq_ff[0];
      yeven       = (rem_in == '0) && !quo_in[0];
      final_ratio = '0;
      priority if (xeven && yeven) begin
         final_status = STATUS_OK;
         final_ratio  = (xq_ff < quo_in) ? DimWidth'(xq_ff >> 1) : DimWidth'(quo_in >> 1);
      end else if (xeven) begin
         if (xq_ff > quo_in) begin
            final_status = STATUS_NOT_SMALLER;
         end else begin
            final_status = STATUS_OK;
            final_ratio  = DimWidth'(xq_ff >> 1);
         end
      end else if (yeven) begin
         if (xq_ff < quo_in) begin
            final_status = STATUS_NOT_SMALLER;
         end else begin
            final_status = STATUS_OK;
            final_ratio  = DimWidth'(quo_in >> 1);
         end
      end else begin
         final_status = STATUS_NO_MULTIPLE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         RAT_IDLE: begin
            if (start && !abort && pre_status == STATUS_OK) begin
               state_in = RAT_DIV_X;
            end
         end
         RAT_DIV_X: begin
            if (abort) begin
               state_in = RAT_IDLE;
            end else if (last_step) begin
               state_in = RAT_DIV_Y;
            end
         end
         RAT_DIV_Y: begin
            if (abort || last_step) begin
               state_in = RAT_IDLE;
            end
         end
         default: state_in = RAT_IDLE;
      endcase
   end

   // control and results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= RAT_IDLE;
         done_ff   <= 1'b0;
         status_ff <= STATUS_OK;
         ratio_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= 1'b0;
         if (!abort) begin
            if (state_ff == RAT_IDLE && start && pre_status != STATUS_OK) begin
               status_ff <= pre_status;
               ratio_ff  <= '0;
               done_ff   <= 1'b1;
            end
            if (state_ff == RAT_DIV_Y && last_step) begin
               status_ff <= final_status;
               ratio_ff  <= final_ratio;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   // divider datapath
   always_ff @(posedge clock) begin
      if (state_ff == RAT_IDLE) begin
         if (start) begin
            sw_ff  <= sw_eff;
            sh_ff  <= sh_eff;
            quo_ff <= target_width;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
      end else if (state_ff == RAT_DIV_X && last_step) begin
         xq_ff  <= quo_in;
         xz_ff  <= rem_in == '0;
         quo_ff <= target_height;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CntWidth'(1);
      end
   end

   assign done     = done_ff;
   assign status   = status_ff;
   assign ratio    = ratio_ff;
   assign strips_w = sw_ff;
   assign strips_h = sh_ff;

endmodule

/* design/esp_strip_fill.sv */
// Strip table builder: walks the target pixel pairs of one axis and writes
// each strip's repeat count once. Depends on esp_pkg.
module esp_strip_fill import esp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                abort,
   input  logic [DimWidth-1:0] strips,
   input  logic [TgtWidth-1:0] tdim,
   input  logic [DimWidth-1:0] ratio,
   output esp_wr_type          wr,
   output logic                done
);

   fill_state_type          state_ff, state_in;
   logic [DimWidth-1:0]     strips_ff, ratio_ff, half_ff, sdim_ff;
   logic [DimWidth-1:0]     rem_ff, sub_ff, raw_ff, cur_ff, t_ff;
   logic [CountWidth-1:0]   acc_ff;
   logic [DimWidth-1:0]     strip_now;
   logic                    changed;
   logic [TgtWidth-1:0]     sum;
   logic                    wrap_q;
   logic [TgtWidth-1:0]     sub_next;
   logic [2*DimWidth-1:0]   product;
   logic                    last_pair;

   // per-pair arithmetic: the rounded source position advances by at most
   // one per pair, so a running remainder replaces the division
   always_comb begin
      strip_now = (raw_ff >= strips_ff) ? (strips_ff - DimWidth'(1)) : raw_ff;
      changed   = strip_now != cur_ff;
      sum       = {1'b0, rem_ff} + {1'b0, sdim_ff};
      wrap_q    = sum >= {1'b0, half_ff};
      sub_next  = {1'b0, sub_ff} + TgtWidth'(1);
      product   = strips_ff * ratio_ff;
      last_pair = t_ff == (half_ff - DimWidth'(1));
   end

   // write out a strip when the walk leaves it, and the last one at the end
   always_comb begin
      wr.en   = (state_ff == FILL_RUN && changed) || state_ff == FILL_FLUSH;
      wr.addr = cur_ff[AddrWidth-1:0];
      wr.data = acc_ff;
      done    = state_ff == FILL_FLUSH;
   end

   // next state; a new walk may start straight from the flush cycle
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FILL_IDLE:  if (start && !abort) state_in = FILL_PREP;
         FILL_PREP:  state_in = abort ? FILL_IDLE : FILL_RUN;
         FILL_RUN: begin
            if (abort) begin
               state_in = FILL_IDLE;
            end else if (last_pair) begin
               state_in = FILL_FLUSH;
            end
         end
         FILL_FLUSH: state_in = (start && !abort) ? FILL_PREP : FILL_IDLE;
         default:    state_in = FILL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FILL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         FILL_IDLE, FILL_FLUSH: begin
            if (start) begin
               strips_ff <= strips;
               ratio_ff  <= ratio;
               half_ff   <= tdim[TgtWidth-1:1];
            end
         end
         FILL_PREP: begin
            sdim_ff <= product[DimWidth-1:0];
            rem_ff  <= half_ff >> 1;
            sub_ff  <= '0;
            raw_ff  <= '0;
            cur_ff  <= '0;
            acc_ff  <= '0;
            t_ff    <= '0;
         end
         FILL_RUN: begin
            if (changed) begin
               cur_ff <= strip_now;
               acc_ff <= CountWidth'(2);
            end else begin
               acc_ff <= acc_ff + CountWidth'(2);
            end
            if (wrap_q) begin
               rem_ff <= DimWidth'(sum - {1'b0, half_ff});
               if (sub_next == {1'b0, ratio_ff}) begin
                  sub_ff <= '0;
                  raw_ff <= raw_ff + DimWidth'(1);
               end else begin
                  sub_ff <= sub_next[DimWidth-1:0];
               end
            end else begin
               rem_ff <= sum[DimWidth-1:0];
            end
            t_ff <= t_ff + DimWidth'(1);
         end
         default: ;
      endcase
   end

endmodule

/* design/even_strip_point_upscaler_top.sv */
// Channel | role   | ports                      | payload
// req     | input  | req_valid / req_stall      | source pixel
// rsp     | output | rsp_valid / rsp_stall      | pixel, repeats, marks, status
// csr     | config | csr_write_enable / _index  | csr_write_data, no read-back
//
// One request per cycle once the count tables are built and no response is stalled.
// At the first pixel of each frame the tables are rebuilt while requests stall:
// first the bit-serial divider (two 14-step divisions), then the one-pair-a-cycle
// strip walk over each axis; an error frame skips the walk.
// Reset is synchronous; the count memories need no clearing, a strip count
// bounds what reads as written. A stalled response holds the request side
// off. Depends on esp_pkg and the sub-blocks.
module even_strip_point_upscaler_top import esp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PixelWidth-1:0]    req_source_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PixelWidth-1:0]    rsp_pixel_value,
   output logic [CountWidth-1:0]    rsp_column_repeat,
   output logic [CountWidth-1:0]    rsp_row_repeat,
   output logic                     rsp_last_in_row,
   output logic                     rsp_last_in_frame,
   output logic [StatusWidth-1:0]   rsp_status,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   logic [DimWidth-1:0]     sw_ff, sh_ff;
   logic [TgtWidth-1:0]     tw_ff, th_ff;
   logic                    half_ff;
   top_state_type           state_ff, state_in;
   logic                    built_ff, built_in;
   logic                    half_b_ff;
   logic [AddrWidth-1:0]    col_ff, row_ff;
   logic                    s1_valid_ff;
   logic [PixelWidth-1:0]   s1_pixel_ff;
   logic                    s1_last_row_ff, s1_last_frame_ff;
   logic                    s1_col_ok_ff, s1_row_ok_ff;
   logic                    s1_col_odd_ff, s1_row_odd_ff, s1_half_ff;
   status_type              s1_status_ff;
   logic                    at_origin, req_accept, rsp_accept;
   logic                    row_end, frame_end;
   logic [AddrWidth-1:0]    col_strip, row_strip;
   logic                    ratio_start, fill_start;
   logic                    rat_done, fill_done;
   status_type              rat_status;
   logic [DimWidth-1:0]     rat_ratio, rat_strips_w, rat_strips_h;
   logic [DimWidth-1:0]     fill_strips;
   logic [TgtWidth-1:0]     fill_tdim;
   esp_wr_type              fill_wr, col_wr, row_wr;
   logic [CountWidth-1:0]   col_count, row_count;
   logic [CountWidth:0]     col_up, row_up;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff   <= DimWidth'(320);
         sh_ff   <= DimWidth'(200);
         tw_ff   <= TgtWidth'(640);
         th_ff   <= TgtWidth'(400);
         half_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  sw_ff   <= csr_write_data[DimWidth-1:0];
            CSR_SOURCE_HEIGHT: sh_ff   <= csr_write_data[DimWidth-1:0];
            CSR_TARGET_WIDTH:  tw_ff   <= csr_write_data[TgtWidth-1:0];
            CSR_TARGET_HEIGHT: th_ff   <= csr_write_data[TgtWidth-1:0];
            CSR_HALF_RES:      half_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // stream handshake; no request is taken while the tables are written
   always_comb begin
      at_origin  = col_ff == '0 && row_ff == '0;
      req_stall  = !(state_ff == TOP_IDLE && (built_ff || !at_origin))
                   || (s1_valid_ff && rsp_stall);
      req_accept = req_valid && !req_stall;
      rsp_accept = s1_valid_ff && !rsp_stall;
      row_end    = ({1'b0, col_ff} + DimWidth'(1) >= sw_ff) || (col_ff == '1);
      frame_end  = row_end && (({1'b0, row_ff} + DimWidth'(1) >= sh_ff) || (row_ff == '1));
      col_strip  = half_b_ff ? {1'b0, col_ff[AddrWidth-1:1]} : col_ff;
      row_strip  = half_b_ff ? {1'b0, row_ff[AddrWidth-1:1]} : row_ff;
   end

   // table build sequencer; a register write aborts it and marks the tables unbuilt
   always_comb begin
      state_in    = state_ff;
      ratio_start = 1'b0;
      fill_start  = 1'b0;
      built_in    = built_ff;
      unique case (state_ff)
         TOP_IDLE: begin
            if (req_valid && at_origin && !built_ff && !csr_write_enable) begin
               ratio_start = 1'b1;
               state_in    = TOP_RATIO;
            end
         end
         TOP_RATIO: begin
            if (csr_write_enable) begin
               state_in = TOP_IDLE;
            end else if (rat_done) begin
               if (rat_status == STATUS_OK) begin
                  fill_start = 1'b1;
                  state_in   = TOP_FILL_COL;
               end else begin
                  built_in = 1'b1;
                  state_in = TOP_IDLE;
               end
            end
         end
         TOP_FILL_COL: begin
            if (csr_write_enable) begin
               state_in = TOP_IDLE;
            end else if (fill_done) begin
               fill_start = 1'b1;
               state_in   = TOP_FILL_ROW;
            end
         end
         TOP_FILL_ROW: begin
            if (csr_write_enable) begin
               state_in = TOP_IDLE;
            end else if (fill_done) begin
               built_in = 1'b1;
               state_in = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
      if (csr_write_enable || (req_accept && at_origin)) begin
         built_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TOP_IDLE;
         built_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         built_ff <= built_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ratio_start) begin
         half_b_ff <= half_ff;
      end
   end

   // ratio unit and strip walker
   esp_ratio u_ratio (
      .clock           (clock),
      .reset           (reset),
      .start           (ratio_start),
      .abort           (csr_write_enable),
      .source_width    (sw_ff),
      .source_height   (sh_ff),
      .target_width    (tw_ff),
      .target_height   (th_ff),
      .half_resolution (half_ff),
      .done            (rat_done),
      .status          (rat_status),
      .ratio           (rat_ratio),
      .strips_w        (rat_strips_w),
      .strips_h        (rat_strips_h)
   );

   assign fill_strips = (state_ff == TOP_RATIO) ? rat_strips_w : rat_strips_h;
   assign fill_tdim   = (state_ff == TOP_RATIO) ? tw_ff : th_ff;

   esp_strip_fill u_fill (
      .clock  (clock),
      .reset  (reset),
      .start  (fill_start),
      .abort  (csr_write_enable),
      .strips (fill_strips),
      .tdim   (fill_tdim),
      .ratio  (rat_ratio),
      .wr     (fill_wr),
      .done   (fill_done)
   );

   // route walker writes to the table of the axis being built
   always_comb begin
      col_wr    = fill_wr;
      row_wr    = fill_wr;
      col_wr.en = fill_wr.en && state_ff == TOP_FILL_COL;
      row_wr.en = fill_wr.en && state_ff == TOP_FILL_ROW;
   end

   esp_count_mem u_col_mem (
      .clock   (clock),
      .wr      (col_wr),
      .rd_en   (req_accept),
      .rd_addr (col_strip),
      .rd_data (col_count)
   );

   esp_count_mem u_row_mem (
      .clock   (clock),
      .wr      (row_wr),
      .rd_en   (req_accept),
      .rd_addr (row_strip),
      .rd_data (row_count)
   );

   // raster position
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         if (frame_end) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (row_end) begin
            col_ff <= '0;
            row_ff <= row_ff + AddrWidth'(1);
         end else begin
            col_ff <= col_ff + AddrWidth'(1);
         end
      end
   end

   // response stage, alongside the memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff      <= req_source_pixel;
         s1_last_row_ff   <= row_end;
         s1_last_frame_ff <= frame_end;
         s1_col_ok_ff     <= {1'b0, col_strip} < rat_strips_w;
         s1_row_ok_ff     <= {1'b0, row_strip} < rat_strips_h;
         s1_col_odd_ff    <= col_ff[0];
         s1_row_odd_ff    <= row_ff[0];
         s1_half_ff       <= half_b_ff;
         s1_status_ff     <= rat_status;
      end
   end

   // half mode: even entry takes the ceil half of the strip, odd the floor
   always_comb begin
      col_up = {1'b0, col_count} + (CountWidth + 1)'(1);
      row_up = {1'b0, row_count} + (CountWidth + 1)'(1);
      if (s1_status_ff != STATUS_OK || !s1_col_ok_ff) begin
         rsp_column_repeat = '0;
      end else if (s1_half_ff) begin
         rsp_column_repeat = s1_col_odd_ff ? (col_count >> 1) : col_up[CountWidth:1];
      end else begin
         rsp_column_repeat = col_count;
      end
      if (s1_status_ff != STATUS_OK || !s1_row_ok_ff) begin
         rsp_row_repeat = '0;
      end else if (s1_half_ff) begin
         rsp_row_repeat = s1_row_odd_ff ? (row_count >> 1) : row_up[CountWidth:1];
      end else begin
         rsp_row_repeat = row_count;
      end
   end

   assign rsp_valid         = s1_valid_ff;
   assign rsp_pixel_value   = s1_pixel_ff;
   assign rsp_last_in_row   = s1_last_row_ff;
   assign rsp_last_in_frame = s1_last_frame_ff;
   assign rsp_status        = s1_status_ff;

endmodule

/* design/esp_checker.sv */
// Port-level checks of the upscaler top, attached by the bind below.
// Depends on esp_pkg and even_strip_point_upscaler_top.
module esp_checker import esp_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [PixelWidth-1:0]    req_source_pixel,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [PixelWidth-1:0]    rsp_pixel_value,
   input logic [CountWidth-1:0]    rsp_column_repeat,
   input logic [CountWidth-1:0]    rsp_row_repeat,
   input logic                     rsp_last_in_row,
   input logic                     rsp_last_in_frame,
   input logic [StatusWidth-1:0]   rsp_status
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_value))
      else $error("stalled response changed");

   // error frames carry no repeats
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_column_repeat == '0 && rsp_row_repeat == '0)
      else $error("repeat count on error frame");

   // a frame ends only at a row end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_in_frame |-> rsp_last_in_row)
      else $error("frame end off a row end");

   // request taken goes straight to the response register
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid && rsp_pixel_value == $past(req_source_pixel))
      else $error("accepted request lost");

endmodule

bind even_strip_point_upscaler_top esp_checker u_esp_checker (.*);

/* tb/sv/even_strip_point_upscaler_top_tb.sv */
// Self-checking testbench of the even strip point upscaler top level.
// Depends on esp_pkg and even_strip_point_upscaler_top; holds its own frame
// predictor, a request driver, a random response stall and one checker.
module even_strip_point_upscaler_top_tb;
   import esp_pkg::*;

   typedef struct {
      logic [PixelWidth-1:0]  pixel;
      logic [CountWidth-1:0]  col_rep;
      logic [CountWidth-1:0]  row_rep;
      logic                   row_end;
      logic                   frame_end;
      status_type             status;
   } strip_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [PixelWidth-1:0]    req_source_pixel;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [PixelWidth-1:0]    rsp_pixel_value;
   logic [CountWidth-1:0]    rsp_column_repeat;
   logic [CountWidth-1:0]    rsp_row_repeat;
   logic                     rsp_last_in_row;
   logic                     rsp_last_in_frame;
   logic [StatusWidth-1:0]   rsp_status;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_write_data;

   // shadow of the block's registers and frame state
   int unsigned   src_w, src_h, tgt_w, tgt_h, half_res;
   int unsigned   col_counts [MaxSourceDim];
   int unsigned   row_counts [MaxSourceDim];
   int unsigned   col_pos, row_pos, tables_built;
   status_type    frame_status;

   strip_result_type expected_strips[$];
   int            error_count;
   int            results_seen;
   int            frames_sent;
   int            idle_pct;
   int            stall_pct;

   even_strip_point_upscaler_top dut (.*);

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // random response stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // pick the scale ratio; returns the frame status
   function automatic status_type pick_ratio(output int unsigned sw, output int unsigned sh,
                                             output int unsigned ratio);
      int unsigned xr, yr;
      bit          xeven, yeven;
      sw = src_w;
      sh = src_h;
      ratio = 0;
      if ((tgt_w & 1) || (tgt_h & 1)) return STATUS_ODD_TARGET;
      if (half_res && ((sw & 1) || (sh & 1))) return STATUS_ODD_SOURCE;
      if (sw > MaxSourceDim || sh > MaxSourceDim) return STATUS_NO_MULTIPLE;
      if (tgt_w == 0 || tgt_h == 0 || tgt_w > MaxTargetDim || tgt_h > MaxTargetDim)
         return STATUS_NO_MULTIPLE;
      if (half_res) begin
         sw = sw / 2;
         sh = sh / 2;
      end
      if (sw == 0 || sh == 0) return STATUS_NO_MULTIPLE;
      xr = tgt_w / sw;
      yr = tgt_h / sh;
      xeven = (tgt_w % (2 * sw)) == 0;
      yeven = (tgt_h % (2 * sh)) == 0;
      if (xeven && yeven) begin
         ratio = (xr < yr) ? tgt_w / (2 * sw) : tgt_h / (2 * sh);
      end else if (xeven) begin
         if (xr > yr) return STATUS_NOT_SMALLER;
         ratio = tgt_w / (2 * sw);
      end else if (yeven) begin
         if (xr < yr) return STATUS_NOT_SMALLER;
         ratio = tgt_h / (2 * sh);
      end else begin
         return STATUS_NO_MULTIPLE;
      end
      return STATUS_OK;
   endfunction

   // nearest-neighbour pair map of one axis, then the optional half split
   function automatic void fill_axis(ref int unsigned tab[MaxSourceDim], input int unsigned strips,
                                     input int unsigned tdim, input int unsigned ratio);
      longint unsigned half, sdim, s, v;
      int              j;
      half = tdim / 2;
      sdim = longint'(strips) * ratio;
      for (longint unsigned t = 0; t < half; t++) begin
         s = ((t * sdim + half / 2) / half) / ratio;
         if (s >= strips) s = strips - 1;
         tab[s] += 2;
      end
      if (half_res) begin
         for (j = strips - 1; j >= 0; j--) begin
            v = tab[j];
            tab[2 * j + 1] = 32'(v / 2);
            tab[2 * j] = 32'((v + 1) / 2);
         end
      end
   endfunction

   function automatic void build_counts();
      int unsigned sw, sh, ratio;
      for (int i = 0; i < MaxSourceDim; i++) begin
         col_counts[i] = 0;
         row_counts[i] = 0;
      end
      frame_status = pick_ratio(sw, sh, ratio);
      if (frame_status == STATUS_OK) begin
         fill_axis(col_counts, sw, tgt_w, ratio);
         fill_axis(row_counts, sh, tgt_h, ratio);
      end
      tables_built = 1;
   endfunction

   // expected response of one accepted request
   function automatic strip_result_type predict_strip(logic [PixelWidth-1:0] pix);
      strip_result_type r;
      int unsigned   col, row;
      if (!tables_built || (col_pos == 0 && row_pos == 0)) build_counts();
      col = col_pos % MaxSourceDim;
      row = row_pos % MaxSourceDim;
      r.pixel = pix;
      r.row_end = (col + 1 >= src_w) || (col + 1 >= MaxSourceDim);
      r.frame_end = r.row_end && ((row + 1 >= src_h) || (row + 1 >= MaxSourceDim));
      r.col_rep = (frame_status == STATUS_OK) ? col_counts[col][CountWidth-1:0] : '0;
      r.row_rep = (frame_status == STATUS_OK) ? row_counts[row][CountWidth-1:0] : '0;
      r.status = frame_status;
      if (r.frame_end) begin
         col_pos = 0;
         row_pos = 0;
         tables_built = 0;
      end else if (r.row_end) begin
         col_pos = 0;
         row_pos = row + 1;
      end else begin
         col_pos = col + 1;
      end
      return r;
   endfunction

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      strip_result_type e;
      if (!reset && req_valid && !req_stall) expected_strips.push_back(predict_strip(req_source_pixel));
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_strips.size() == 0) begin
            $display("%0t: unexpected response, pixel %0h", $time, rsp_pixel_value);
            error_count++;
         end else begin
            e = expected_strips.pop_front();
            check_field("pixel_value", e.pixel, rsp_pixel_value);
            check_field("column_repeat", e.col_rep, rsp_column_repeat);
            check_field("row_repeat", e.row_rep, rsp_row_repeat);
            check_field("last_in_row", e.row_end, rsp_last_in_row);
            check_field("last_in_frame", e.frame_end, rsp_last_in_frame);
            check_field("status", e.status, rsp_status);
         end
      end
   end

   task automatic send_request(logic [PixelWidth-1:0] pix);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_source_pixel <= pix;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_strips.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CsrDataWidth-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_SOURCE_WIDTH:  src_w = value;
         CSR_SOURCE_HEIGHT: src_h = value;
         CSR_TARGET_WIDTH:  tgt_w = value;
         CSR_TARGET_HEIGHT: tgt_h = value;
         default:           half_res = value & 1;
      endcase
   endtask

   // new geometry between frames, only once the block has gone quiet
   task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned tw,
                               int unsigned th, int unsigned hr);
      drain();
      write_csr(CSR_SOURCE_WIDTH, sw);
      write_csr(CSR_SOURCE_HEIGHT, sh);
      write_csr(CSR_TARGET_WIDTH, tw);
      write_csr(CSR_TARGET_HEIGHT, th);
      write_csr(CSR_HALF_RES, hr);
   endtask

   // one whole frame of random pixels, optional pause until drained
   task automatic send_frame(bit pause_mid);
      int unsigned n;
      n = src_w * src_h;
      for (int unsigned i = 0; i < n; i++) begin
         if (pause_mid && i == n / 2) drain();
         send_request($urandom());
      end
      frames_sent++;
   endtask

   task automatic test_pixel_extremes();
      set_geometry(2, 3, 4, 6, 0);
      send_request('0);
      send_request('1);
      send_request(32'hAAAA_5555);
      send_request(32'h5555_AAAA);
      send_request(32'h8000_0001);
      send_request(32'h7FFF_FFFE);
      frames_sent++;
   endtask

   task automatic test_error_status();
      set_geometry(2, 2, 5, 4, 0);   // odd target
      send_frame(0);
      set_geometry(3, 2, 12, 8, 1);  // odd source in half mode
      send_frame(0);
      set_geometry(2, 2, 8, 6, 0);   // even ratio not the smaller one
      send_frame(0);
      set_geometry(2, 2, 6, 6, 0);   // no even multiple
      send_frame(0);
   endtask

   task automatic test_half_and_rounding();
      set_geometry(4, 2, 16, 8, 1);
      send_frame(0);
      set_geometry(2, 2, 16, 4, 0);  // rounding past the last strip
      send_frame(0);
      set_geometry(1, 1, 2, 2, 0);
      send_frame(0);
   endtask

   task automatic test_size_extremes();
      set_geometry(1, 1, MaxTargetDim, MaxTargetDim, 0);      // widest strips
      send_frame(0);
      set_geometry(2, 2, MaxTargetDim, MaxTargetDim, 1);
      send_frame(0);
      set_geometry(1, 1, MaxTargetDim + 2, 4, 0);             // target out of range
      send_frame(0);
      set_geometry(0, 2, 4, 4, 0);                            // zero source width
      send_request(32'h0123_4567);
      send_request(32'h89AB_CDEF);
      frames_sent++;
   endtask

   // random frames, mostly consistent geometry, some arbitrary targets
   task automatic test_random_frames(int unsigned budget);
      int unsigned sent, sw, sh, tw, th, hr, r;
      sent = 0;
      while (sent < budget) begin
         hr = ($urandom_range(3) == 0);
         sw = $urandom_range(1, 10);
         sh = $urandom_range(1, 6);
         if (hr && $urandom_range(7) != 0) begin
            sw = sw + (sw & 1);
            sh = sh + (sh & 1);
         end
         r = $urandom_range(1, 4);
         tw = 2 * r * sw;
         th = 2 * r * sh * $urandom_range(1, 2);
         if ($urandom_range(4) == 0) tw = $urandom_range(1, 40);
         if ($urandom_range(4) == 0) th = 2 * $urandom_range(1, 30);
         set_geometry(sw, sh, tw, th, hr);
         send_frame($urandom_range(9) == 0);
         sent += sw * sh;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_source_pixel = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_SOURCE_WIDTH;
      csr_write_data = '0;
      src_w = 320; src_h = 200; tgt_w = 640; tgt_h = 400; half_res = 0;
      col_pos = 0; row_pos = 0; tables_built = 0; frame_status = STATUS_OK;
      error_count = 0; results_seen = 0; frames_sent = 0;
      idle_pct = 0; stall_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_pixel_extremes();
      test_error_status();
      test_half_and_rounding();
      idle_pct = 62;
      test_size_extremes();
      idle_pct = 0;
      test_random_frames(150);
      idle_pct = 62;
      test_random_frames(150);
      idle_pct = 0; stall_pct = 62;
      test_random_frames(150);
      idle_pct = 16; stall_pct = 16;
      test_random_frames(150);

      drain();
      repeat (40) @(posedge clock);
      $display("Covered %0d frames and %0d responses: all statuses, half mode, size extremes,",
               frames_sent, results_seen);
      $display("random geometry under sender gaps and response stalls.");
      if (error_count == 0 && expected_strips.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // run limit
   initial begin
      #8000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
design/esp_pkg.sv
design/esp_count_mem.sv
design/esp_ratio.sv
design/esp_strip_fill.sv
design/even_strip_point_upscaler_top.sv
design/esp_checker.sv
tb/sv/even_strip_point_upscaler_top_tb.sv
